// ===== rtl/serial_bank_mapper_macros.svh =====
// ----------------------------------------------------------------------------
// Serial bank mapper assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BANK_MAPPER_MACROS_SVH
`define SERIAL_BANK_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
`define SBM_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("serial bank mapper check failed");
`define SBM_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("serial bank mapper check failed");
`else
`define SBM_ASSERT_NOW(label, cond, prop)
`define SBM_ASSERT_NEXT(label, cond, prop)
`endif

`endif

// ===== rtl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper package
// Request and result payload types and the register codes of the mapper.
// ----------------------------------------------------------------------------
package sbm_pkg;

	typedef struct packed {
		logic [15:0] cpu_address;
		logic [7:0]  write_data;
		logic [31:0] cpu_cycle;
	} sbm_req_t;

	typedef struct packed {
		logic       accepted;
		logic       committed;
		logic [1:0] mirroring;
		logic [4:0] pattern_low_page;
		logic [4:0] pattern_high_page;
		logic [3:0] program_low_bank;
		logic [3:0] program_high_bank;
		logic       work_ram_enable;
		logic       board_ram_bit_a;
		logic       board_ram_bit_b;
	} sbm_rsp_t;

	typedef enum logic [1:0] {
		REG_CONTROL   = 2'd0,
		REG_PATTERN_A = 2'd1,
		REG_PATTERN_B = 2'd2,
		REG_PROGRAM   = 2'd3
	} sbm_reg_sel_t;

	localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;
	localparam logic [4:0] CONTROL_RESET     = 5'h0c;
	localparam logic [3:0] PRG_LAST_BANK     = 4'hf;
	localparam logic [2:0] LAST_BIT_INDEX    = 3'd4;

endpackage

// ===== rtl/sbm_if.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper channels
// Valid/ready channels for CPU write requests and mapping results.
// ----------------------------------------------------------------------------
interface sbm_req_if;
	import sbm_pkg::*;

	logic     valid;
	logic     ready;
	sbm_req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sbm_rsp_if;
	import sbm_pkg::*;

	logic     valid;
	logic     ready;
	sbm_rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/serial_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper
// Five-bit serial loader for cartridge bank registers with bank remapping.
// ----------------------------------------------------------------------------
// The request channel carries one CPU write to the mapper window: address,
// data byte and a 32-bit cycle stamp. Every request yields exactly one result
// on the result channel: the filter and commit flags and the mapping in force
// after the write. The pattern-ROM flag is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, which is not enforced.
// A request is taken into an input register, decoded combinationally, and its
// result is loaded into the output register. The block takes one request per
// clock while the result receiver does not stall; a single decode step lies
// between the two registers. When the result receiver stalls, the output
// register holds its result and the input register holds one more request;
// the request channel then drops ready until the result is taken.
// Reset clears both valid flags, the shift latch and the stamp, loads the
// control register with mode 3 and restores the power-on mapping at once.
// ----------------------------------------------------------------------------
`include "serial_bank_mapper_macros.svh"

module serial_bank_mapper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	sbm_req_if.sink    request,
	sbm_rsp_if.source  result
);
	import sbm_pkg::*;

	logic     valid_s1;
	sbm_req_t req_s1;
	logic     valid_s2;
	sbm_rsp_t rsp_s2;
	logic     step;

	logic        pattern_rom_q;
	logic [4:0]  latch_q;
	logic [2:0]  bit_cnt_q;
	logic [4:0]  ctrl_q;
	logic [4:0]  chr_a_q;
	logic [4:0]  chr_b_q;
	logic [4:0]  prg_q;
	logic [31:0] stamp_q;
	logic        stamp_vld_q;
	logic [1:0]  mirror_q;
	logic [4:0]  chr_page0_q;
	logic [4:0]  chr_page1_q;
	logic [3:0]  prg_bank0_q;
	logic [3:0]  prg_bank1_q;
	logic        wram_en_q;
	logic        board_a_q;
	logic        board_b_q;

	logic [31:0] delta;
	logic        accepted;
	logic        commit;
	logic [4:0]  latch_full;
	logic [4:0]  latch_n;
	logic [2:0]  bit_cnt_n;
	logic [4:0]  ctrl_n;
	logic [4:0]  chr_a_n;
	logic [4:0]  chr_b_n;
	logic [4:0]  prg_n;
	logic [1:0]  mirror_n;
	logic [4:0]  chr_page0_n;
	logic [4:0]  chr_page1_n;
	logic [3:0]  prg_bank0_n;
	logic [3:0]  prg_bank1_n;
	logic        wram_en_n;
	logic        board_a_n;
	logic        board_b_n;

	assign step          = valid_s1 && (!valid_s2 || result.ready);
	assign request.ready = !valid_s1 || step;
	assign result.valid  = valid_s2;
	assign result.payload = rsp_s2;

	// The stamp filter rejects a write whose stamp is zero or one above the stamp of the last write.
	assign delta      = req_s1.cpu_cycle - stamp_q;
	assign accepted   = !stamp_vld_q || (delta[31:1] != 31'd0);
	assign latch_full = latch_q | ({4'd0, req_s1.write_data[0]} << bit_cnt_q);
	assign commit     = accepted && (req_s1.write_data[7] || (bit_cnt_q == LAST_BIT_INDEX));

	always_comb begin
		latch_n   = latch_q;
		bit_cnt_n = bit_cnt_q;
		ctrl_n    = ctrl_q;
		chr_a_n   = chr_a_q;
		chr_b_n   = chr_b_q;
		prg_n     = prg_q;
		if (accepted) begin
			if (req_s1.write_data[7]) begin
				latch_n   = 5'd0;
				bit_cnt_n = 3'd0;
				ctrl_n    = ctrl_q | CONTROL_RESET;
			end else if (bit_cnt_q == LAST_BIT_INDEX) begin
				latch_n   = 5'd0;
				bit_cnt_n = 3'd0;
				unique case (sbm_reg_sel_t'(req_s1.cpu_address[14:13]))
					REG_CONTROL:   ctrl_n  = latch_full;
					REG_PATTERN_A: chr_a_n = latch_full;
					REG_PATTERN_B: chr_b_n = latch_full;
					REG_PROGRAM:   prg_n   = latch_full;
					default:       prg_n   = latch_full;
				endcase
			end else begin
				latch_n   = latch_full;
				bit_cnt_n = bit_cnt_q + 3'd1;
			end
		end
	end

	always_comb begin
		mirror_n    = mirror_q;
		chr_page0_n = chr_page0_q;
		chr_page1_n = chr_page1_q;
		prg_bank0_n = prg_bank0_q;
		prg_bank1_n = prg_bank1_q;
		wram_en_n   = wram_en_q;
		board_a_n   = board_a_q;
		board_b_n   = board_b_q;
		if (commit) begin
			mirror_n = ctrl_n[1:0];
			if (pattern_rom_q) begin
				if (ctrl_n[4]) begin
					chr_page0_n = chr_a_n;
					chr_page1_n = chr_b_n;
				end else begin
					chr_page0_n = {chr_a_n[4:1], 1'b0};
					chr_page1_n = {chr_a_n[4:1], 1'b1};
				end
			end else begin
				if (ctrl_n[4]) begin
					chr_page0_n = {4'd0, chr_a_n[0]};
					chr_page1_n = {4'd0, chr_b_n[0]};
				end else begin
					chr_page0_n = 5'd0;
					chr_page1_n = 5'd1;
				end
				board_a_n = chr_a_n[4];
				board_b_n = chr_b_n[4];
			end
			case (ctrl_n[3:2])
				PRG_MODE_FIX_LOW: begin
					prg_bank0_n = 4'd0;
					prg_bank1_n = prg_n[3:0];
				end
				PRG_MODE_FIX_HIGH: begin
					prg_bank0_n = prg_n[3:0];
					prg_bank1_n = PRG_LAST_BANK;
				end
				default: begin
					prg_bank0_n = {prg_n[3:1], 1'b0};
					prg_bank1_n = {prg_n[3:1], 1'b1};
				end
			endcase
			wram_en_n = !prg_n[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_rom_q <= 1'b1;
		end else if (cfg_we) begin
			pattern_rom_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			req_s1 <= request.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_s2.accepted          <= accepted;
			rsp_s2.committed         <= commit;
			rsp_s2.mirroring         <= mirror_n;
			rsp_s2.pattern_low_page  <= chr_page0_n;
			rsp_s2.pattern_high_page <= chr_page1_n;
			rsp_s2.program_low_bank  <= prg_bank0_n;
			rsp_s2.program_high_bank <= prg_bank1_n;
			rsp_s2.work_ram_enable   <= wram_en_n;
			rsp_s2.board_ram_bit_a   <= board_a_n;
			rsp_s2.board_ram_bit_b   <= board_b_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q     <= 5'd0;
			bit_cnt_q   <= 3'd0;
			ctrl_q      <= CONTROL_RESET;
			chr_a_q     <= 5'd0;
			chr_b_q     <= 5'd0;
			prg_q       <= 5'd0;
			stamp_q     <= 32'd0;
			stamp_vld_q <= 1'b0;
			mirror_q    <= 2'd0;
			chr_page0_q <= 5'd0;
			chr_page1_q <= 5'd1;
			prg_bank0_q <= 4'd0;
			prg_bank1_q <= PRG_LAST_BANK;
			wram_en_q   <= 1'b1;
			board_a_q   <= 1'b0;
			board_b_q   <= 1'b0;
		end else if (step) begin
			latch_q     <= latch_n;
			bit_cnt_q   <= bit_cnt_n;
			ctrl_q      <= ctrl_n;
			chr_a_q     <= chr_a_n;
			chr_b_q     <= chr_b_n;
			prg_q       <= prg_n;
			stamp_q     <= req_s1.cpu_cycle;
			stamp_vld_q <= 1'b1;
			mirror_q    <= mirror_n;
			chr_page0_q <= chr_page0_n;
			chr_page1_q <= chr_page1_n;
			prg_bank0_q <= prg_bank0_n;
			prg_bank1_q <= prg_bank1_n;
			wram_en_q   <= wram_en_n;
			board_a_q   <= board_a_n;
			board_b_q   <= board_b_n;
		end
	end

	`SBM_ASSERT_NOW(a_bit_count_range, 1'b1, bit_cnt_q <= LAST_BIT_INDEX)
	`SBM_ASSERT_NOW(a_commit_needs_accept, valid_s2, !rsp_s2.committed || rsp_s2.accepted)
	`SBM_ASSERT_NEXT(a_commit_clears_count, step && commit, bit_cnt_q == 3'd0 && latch_q == 5'd0)
	`SBM_ASSERT_NEXT(a_reset_write_mode, step && accepted && req_s1.write_data[7], ctrl_q[3:2] == 2'b11)

endmodule

// ===== bench/sbm_mapping_checker.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper checker
// Watches the request and result channels and the pattern-ROM flag write
// port. It keeps its own copy of the shift latch, bank registers, cycle
// filter and mapping, predicts one result per accepted request, and compares
// every result field with the oldest prediction.
// ----------------------------------------------------------------------------
module sbm_mapping_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	sbm_req_if          request,
	sbm_rsp_if          result,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	import sbm_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	sbm_rsp_t    expected_mappings[$];
	sbm_rsp_t    mapping;
	logic        rom_flag;
	logic [4:0]  shift_latch;
	logic [2:0]  bit_count;
	logic [4:0]  control_reg;
	logic [4:0]  pattern_a;
	logic [4:0]  pattern_b;
	logic [4:0]  program_reg;
	logic [31:0] last_stamp;
	logic        stamp_seen;
	int unsigned errors;

	task automatic remap();
		logic [3:0] bank;
		bank = program_reg[3:0];
		mapping.mirroring = control_reg[1:0];
		if (rom_flag) begin
			if (control_reg[4]) begin
				mapping.pattern_low_page  = pattern_a;
				mapping.pattern_high_page = pattern_b;
			end else begin
				mapping.pattern_low_page  = {pattern_a[4:1], 1'b0};
				mapping.pattern_high_page = {pattern_a[4:1], 1'b1};
			end
		end else begin
			if (control_reg[4]) begin
				mapping.pattern_low_page  = {4'd0, pattern_a[0]};
				mapping.pattern_high_page = {4'd0, pattern_b[0]};
			end else begin
				mapping.pattern_low_page  = 5'd0;
				mapping.pattern_high_page = 5'd1;
			end
			mapping.board_ram_bit_a = pattern_a[4];
			mapping.board_ram_bit_b = pattern_b[4];
		end
		case (control_reg[3:2])
			PRG_MODE_FIX_LOW: begin
				mapping.program_low_bank  = 4'd0;
				mapping.program_high_bank = bank;
			end
			PRG_MODE_FIX_HIGH: begin
				mapping.program_low_bank  = bank;
				mapping.program_high_bank = PRG_LAST_BANK;
			end
			default: begin
				mapping.program_low_bank  = {bank[3:1], 1'b0};
				mapping.program_high_bank = {bank[3:1], 1'b1};
			end
		endcase
		mapping.work_ram_enable = !program_reg[4];
	endtask

	task automatic predict_write(input sbm_req_t w);
		sbm_rsp_t want;
		logic     take;
		logic     commit;
		take = !stamp_seen || ((w.cpu_cycle - last_stamp) > 32'd1);
		commit = 1'b0;
		if (take) begin
			if (w.write_data[7]) begin
				shift_latch = 5'd0;
				bit_count = 3'd0;
				control_reg = control_reg | CONTROL_RESET;
				commit = 1'b1;
			end else begin
				shift_latch[bit_count] = w.write_data[0];
				if (bit_count == LAST_BIT_INDEX) begin
					case (sbm_reg_sel_t'(w.cpu_address[14:13]))
						REG_CONTROL:   control_reg = shift_latch;
						REG_PATTERN_A: pattern_a = shift_latch;
						REG_PATTERN_B: pattern_b = shift_latch;
						REG_PROGRAM:   program_reg = shift_latch;
					endcase
					shift_latch = 5'd0;
					bit_count = 3'd0;
					commit = 1'b1;
				end else begin
					bit_count = bit_count + 3'd1;
				end
			end
			if (commit)
				remap();
		end
		last_stamp = w.cpu_cycle;
		stamp_seen = 1'b1;
		want = mapping;
		want.accepted = take;
		want.committed = commit;
		expected_mappings.push_back(want);
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	task automatic compare_result(input sbm_rsp_t got);
		sbm_rsp_t want;
		if (expected_mappings.size() == 0) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("%0t: result with no request waiting", $time);
		end else begin
			want = expected_mappings.pop_front();
			check_field("accepted", want.accepted, got.accepted);
			check_field("committed", want.committed, got.committed);
			check_field("mirroring", want.mirroring, got.mirroring);
			check_field("pattern_low_page", want.pattern_low_page, got.pattern_low_page);
			check_field("pattern_high_page", want.pattern_high_page, got.pattern_high_page);
			check_field("program_low_bank", want.program_low_bank, got.program_low_bank);
			check_field("program_high_bank", want.program_high_bank, got.program_high_bank);
			check_field("work_ram_enable", want.work_ram_enable, got.work_ram_enable);
			check_field("board_ram_bit_a", want.board_ram_bit_a, got.board_ram_bit_a);
			check_field("board_ram_bit_b", want.board_ram_bit_b, got.board_ram_bit_b);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_mappings.delete();
			mapping = '0;
			mapping.pattern_high_page = 5'd1;
			mapping.program_high_bank = PRG_LAST_BANK;
			mapping.work_ram_enable = 1'b1;
			rom_flag = 1'b1;
			shift_latch = 5'd0;
			bit_count = 3'd0;
			control_reg = CONTROL_RESET;
			pattern_a = 5'd0;
			pattern_b = 5'd0;
			program_reg = 5'd0;
			last_stamp = 32'd0;
			stamp_seen = 1'b0;
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (request.valid && request.ready)
				predict_write(request.payload);
			if (result.valid && result.ready)
				compare_result(result.payload);
			if (cfg_we)
				rom_flag = cfg_wdata;
			mismatches <= errors;
			outstanding <= expected_mappings.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Serial bank mapper testbench
// Drives CPU write requests into the mapper with random gaps and result
// stalls: a short directed run over the cycle filter, stamp wrap, reset
// writes and full register loads, then random serial loads, reset writes
// and stray writes under both pattern-ROM settings. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import sbm_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned RANDOM_ITEMS  = 1500;
	localparam logic [7:0]  RESET_REQUEST = 8'h80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned stamp_noise = 0;
	logic [31:0] bus_cycle = 32'd0;
	bit          calm = 1'b0;

	sbm_req_if request_ch();
	sbm_rsp_if result_ch();

	serial_bank_mapper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (request_ch),
		.result    (result_ch)
	);

	sbm_mapping_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.request     (request_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [31:0] stamp_step();
		if ($urandom_range(0, 99) < stamp_noise)
			return $urandom_range(0, 1);
		return $urandom_range(2, 6);
	endfunction

	task automatic send_write(input logic [15:0] address, input logic [7:0] data,
		input logic [31:0] stamp);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			request_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_ch.payload <= '{cpu_address: address, write_data: data, cpu_cycle: stamp};
		request_ch.valid <= 1'b1;
		do @(posedge clk); while (!request_ch.ready);
		sent++;
	endtask

	// Five serial writes, LSB first; the address of the last one picks the register.
	task automatic load_register(input sbm_reg_sel_t target, input logic [4:0] value);
		logic [15:0] address;
		logic [7:0]  data;
		for (int i = 0; i < 5; i++) begin
			address = {($urandom_range(0, 19) != 0), target, 13'($urandom)};
			data = {1'b0, 6'($urandom), value[i]};
			bus_cycle += stamp_step();
			send_write(address, data, bus_cycle);
		end
	endtask

	task automatic drain();
		request_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_rom_flag(input logic value);
		drain();
		repeat (3) @(posedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_side
		int unsigned stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin : stimulus
		int unsigned phase_end;
		int unsigned pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		request_ch.valid <= 1'b0;
		request_ch.payload <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_rom_flag(1'b1);

		// The first write is taken even though its stamp matches the reset stamp.
		send_write(16'h8000, RESET_REQUEST, 32'd0);
		send_write(16'h8000, 8'h01, 32'd0);
		send_write(16'h8000, 8'h01, 32'd1);
		bus_cycle = 32'd1;
		load_register(REG_CONTROL, 5'h1f);
		load_register(REG_PATTERN_A, 5'h1f);
		load_register(REG_PROGRAM, 5'h1f);
		send_write(16'hffff, 8'h7f, 32'hffff_ffff);
		send_write(16'h8000, 8'h00, 32'h0000_0000);
		send_write(16'h6000, 8'hff, 32'h0000_0002);
		bus_cycle = 32'd2;

		for (int phase = 0; phase < 4; phase++) begin
			set_rom_flag(phase[0]);
			if (phase == 2)
				bus_cycle = 32'hffff_ff00;
			stamp_noise = 8;
			phase_end = sent + RANDOM_ITEMS / 4;
			while (sent < phase_end) begin
				calm = ((sent / 100) % 5) == 4;
				pick = $urandom_range(0, 99);
				if (pick < 75) begin
					load_register(sbm_reg_sel_t'($urandom_range(0, 3)), 5'($urandom));
				end else if (pick < 85) begin
					bus_cycle += stamp_step();
					send_write({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)}, bus_cycle);
				end else if (pick < 98) begin
					bus_cycle += (pick < 95) ? stamp_step() : $urandom;
					send_write(16'($urandom), 8'($urandom), bus_cycle);
				end else begin
					drain();
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sbm_pkg.sv
rtl/sbm_if.sv
rtl/serial_bank_mapper.sv
bench/sbm_mapping_checker.sv
bench/testbench.sv
